// File: src/nos_pkg.sv
`default_nettype none
package nos_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;

  localparam logic [15:0] TPB_RESET  = 16'd180;
  localparam logic [23:0] WRAP_RESET = 24'd15999840;
  localparam logic [5:0]  DIV_STEPS  = 6'd32;

  localparam logic [2:0] KIND_NOTE  = 3'd0;
  localparam logic [2:0] KIND_TICK  = 3'd1;
  localparam logic [2:0] KIND_FLUSH = 3'd2;
  localparam logic [2:0] KIND_SET   = 3'd3;
  localparam logic [2:0] KIND_RESET = 3'd4;

  localparam logic [1:0] OUT_NOTE   = 2'd0;
  localparam logic [1:0] OUT_TICK   = 2'd1;
  localparam logic [1:0] OUT_MARKER = 2'd2;

  localparam logic CFG_TPB  = 1'b0;
  localparam logic CFG_WRAP = 1'b1;

  typedef struct packed {
    logic [6:0] pitch;
    logic [4:0] channel;
  } key_t;

  typedef struct packed {
    logic [31:0] target;
    key_t        key;
  } pend_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [4:0]  channel;
    logic [23:0] tick_value;
    logic        off_dropped;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// File: src/nos_ram.sv
`default_nettype none
module nos_ram #(
  parameter int unsigned W     = 12,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/nos_divu.sv
`default_nettype none
module nos_divu
  import nos_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output logic          busy_o,
  output logic [23:0]   rem_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] num_q;
  logic [23:0] rem_q;
  logic [23:0] den_q;
  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;

  assign trial = {rem_q, num_q[31]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      if (req_i.divisor == '0) begin
        busy_q <= 1'b0;
        rem_q  <= req_i.dividend[23:0];
      end else begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_STEPS;
        num_q  <= req_i.dividend;
        rem_q  <= '0;
        den_q  <= req_i.divisor;
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[23:0] : trial[23:0];
      num_q <= {num_q[30:0], 1'b0};
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: src/note_off_scheduler.sv
// Note-off scheduler. Events enter on the s_axis channel, one transfer per
// event, with the event kind in tuser. Results leave on m_axis; tlast marks
// the final result of an event, and an event may cause no result at all.
// Configuration writes (ticks per beat, tick wrap) are taken at any cycle
// with cfg_we_i high and must only be made while the block is idle.
// The active and pending stores sit in two RAMs with one write port and a
// registered read port; every scan step is an address state, then a compare
// state, and removing an entry shifts the newer entries down, each with a
// read state and a write state. A note-on scans the pending store; a
// note-off or a match searches the active store and shifts. A tick waits
// for the remainder unit, then scans the pending store and removes each due
// entry. Flush and reset step through the active notes, with a read state
// and an emit state per note. Events are handled one at a time; a new event
// is taken once the previous one has placed its final result in the output
// register. When the receiver stalls, the block holds at its next result.
// Reset clears the counters and the tick counter and returns the
// configuration registers to their defaults; no memory clearing pass is needed.
`default_nettype none
module note_off_scheduler
  import nos_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pitch[6:0], velocity[13:7], channel[18:14], note_len[34:19],
  // new_tick[66:35], zero fill
  input  wire logic [71:0] s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_pitch[6:0], out_velocity[13:7], out_channel[18:14], tick_value[42:19],
  // off_dropped[43], zero fill
  output logic [47:0]      m_axis_tdata,
  // out_kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PS_RD, ST_PS_CMP, ST_ON_EMIT, ST_SCHED, ST_OFF_EMIT,
    ST_DIV_WAIT, ST_TK_RD, ST_TK_CMP, ST_AS_RD, ST_AS_CMP, ST_AH_RD,
    ST_AH_WR, ST_PH_RD, ST_PH_WR, ST_FL_RD, ST_FL_EM, ST_MARK, ST_FINISH
  } state_e;

  state_e      state_q, a_ret_q, p_ret_q;
  logic [15:0] tpb_q;
  logic [23:0] wrap_q;
  logic [31:0] tick_q;
  logic [CW-1:0] p_used_q, a_used_q, px_q, ax_q, sx_q;
  key_t        key_q;
  logic [6:0]  vel_q;
  logic [15:0] dur_q;
  logic [31:0] prod_q;
  logic        rst_kind_q;
  res_t        hold_q, out_q;
  logic        hold_v_q, m_valid_q, out_last_q;

  logic          act_we, act_re, pnd_we, pnd_re;
  logic [IW-1:0] act_waddr, act_raddr, pnd_waddr, pnd_raddr;
  key_t          act_wdata, act_rd;
  pend_t         pnd_wdata, pnd_rd;
  logic [11:0]   act_rdata;
  logic [43:0]   pnd_rdata;

  div_req_t    div_req;
  logic        div_busy;
  logic [23:0] div_rem;

  logic        accept, out_free, pmatch, amatch, due, drop;
  logic        emit_go, fin_go;
  res_t        emit_val;
  logic [32:0] sum;
  logic [31:0] target;

  logic [6:0]  in_pitch, in_vel;
  logic [4:0]  in_chan;
  logic [15:0] in_dur;
  logic [31:0] in_tick;

  assign in_pitch = s_axis_tdata[6:0];
  assign in_vel   = s_axis_tdata[13:7];
  assign in_chan  = s_axis_tdata[18:14];
  assign in_dur   = s_axis_tdata[34:19];
  assign in_tick  = s_axis_tdata[66:35];

  assign s_axis_tready = (state_q == ST_IDLE) && !hold_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign act_rd = key_t'(act_rdata);
  assign pnd_rd = pend_t'(pnd_rdata);
  assign pmatch = pnd_rd.key == key_q;
  assign amatch = act_rd == key_q;
  assign due    = tick_q >= pnd_rd.target;
  assign drop   = (dur_q != '0) && (p_used_q >= FULL);
  assign sum    = {1'b0, tick_q} + {9'b0, prod_q[31:8]};
  assign target = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign div_req.start    = accept && (s_axis_tuser == KIND_TICK);
  assign div_req.dividend = tick_q;
  assign div_req.divisor  = wrap_q;

  nos_divu u_divu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .rem_o  (div_rem)
  );

  nos_ram #(.W(12), .DEPTH(MAX_ENTRIES), .AW(IW)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_waddr),
    .wdata_i (act_wdata),
    .re_i    (act_re),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  nos_ram #(.W(44), .DEPTH(MAX_ENTRIES), .AW(IW)) u_pnd_ram (
    .clk_i   (clk_i),
    .we_i    (pnd_we),
    .waddr_i (pnd_waddr),
    .wdata_i (pnd_wdata),
    .re_i    (pnd_re),
    .raddr_i (pnd_raddr),
    .rdata_o (pnd_rdata)
  );

  always_comb begin
    act_we    = 1'b0;
    act_re    = 1'b0;
    act_waddr = '0;
    act_raddr = '0;
    act_wdata = key_q;
    pnd_we    = 1'b0;
    pnd_re    = 1'b0;
    pnd_waddr = '0;
    pnd_raddr = '0;
    pnd_wdata = '{target: target, key: key_q};
    emit_go   = 1'b0;
    fin_go    = 1'b0;
    emit_val  = '{kind: OUT_NOTE, pitch: key_q.pitch, velocity: 7'd0,
                  channel: key_q.channel, tick_value: 24'd0, off_dropped: 1'b0};
    case (state_q)
      ST_PS_RD, ST_TK_RD: begin
        pnd_re    = px_q != '0;
        pnd_raddr = IW'(px_q - ONE);
      end
      ST_PS_CMP: begin
        emit_go = pmatch && out_free;
      end
      ST_ON_EMIT: begin
        emit_go              = out_free;
        emit_val.velocity    = vel_q;
        emit_val.off_dropped = drop;
        act_we               = out_free && (a_used_q < FULL);
        act_waddr            = IW'(a_used_q);
      end
      ST_SCHED: begin
        pnd_we    = 1'b1;
        pnd_waddr = IW'(p_used_q);
      end
      ST_OFF_EMIT: begin
        emit_go = out_free;
      end
      ST_DIV_WAIT: begin
        emit_go             = !div_busy && out_free;
        emit_val.kind       = OUT_TICK;
        emit_val.pitch      = 7'd0;
        emit_val.channel    = 5'd0;
        emit_val.tick_value = div_rem;
      end
      ST_TK_CMP: begin
        emit_go          = due && out_free;
        emit_val.pitch   = pnd_rd.key.pitch;
        emit_val.channel = pnd_rd.key.channel;
      end
      ST_AS_RD: begin
        act_re    = ax_q != '0;
        act_raddr = IW'(ax_q - ONE);
      end
      ST_AH_RD: begin
        act_re    = (ax_q + ONE) < a_used_q;
        act_raddr = IW'(ax_q + ONE);
      end
      ST_AH_WR: begin
        act_we    = 1'b1;
        act_waddr = IW'(ax_q);
        act_wdata = act_rd;
      end
      ST_PH_RD: begin
        pnd_re    = (sx_q + ONE) < p_used_q;
        pnd_raddr = IW'(sx_q + ONE);
      end
      ST_PH_WR: begin
        pnd_we    = 1'b1;
        pnd_waddr = IW'(sx_q);
        pnd_wdata = pnd_rd;
      end
      ST_FL_RD: begin
        act_re    = a_used_q != '0;
        act_raddr = IW'(a_used_q - ONE);
      end
      ST_FL_EM: begin
        emit_go          = out_free;
        emit_val.pitch   = act_rd.pitch;
        emit_val.channel = act_rd.channel;
      end
      ST_MARK: begin
        emit_go          = out_free;
        emit_val.kind    = OUT_MARKER;
        emit_val.pitch   = 7'd0;
        emit_val.channel = 5'd0;
      end
      ST_FINISH: begin
        fin_go = hold_v_q && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      a_ret_q    <= ST_FINISH;
      p_ret_q    <= ST_FINISH;
      tpb_q      <= TPB_RESET;
      wrap_q     <= WRAP_RESET;
      tick_q     <= '0;
      p_used_q   <= '0;
      a_used_q   <= '0;
      px_q       <= '0;
      ax_q       <= '0;
      sx_q       <= '0;
      rst_kind_q <= 1'b0;
      hold_v_q   <= 1'b0;
      m_valid_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TPB:  tpb_q  <= cfg_data_i[15:0];
          CFG_WRAP: wrap_q <= cfg_data_i;
          default: ;
        endcase
      end

      if ((emit_go && hold_v_q) || fin_go) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (emit_go) begin
        if (hold_v_q) begin
          out_q      <= hold_q;
          out_last_q <= 1'b0;
        end
        hold_q   <= emit_val;
        hold_v_q <= 1'b1;
      end
      if (fin_go) begin
        out_q      <= hold_q;
        out_last_q <= 1'b1;
        hold_v_q   <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            key_q  <= '{pitch: in_pitch, channel: in_chan};
            vel_q  <= in_vel;
            dur_q  <= in_dur;
            prod_q <= in_dur * tpb_q;
            case (s_axis_tuser)
              KIND_NOTE: begin
                px_q    <= p_used_q;
                state_q <= (in_vel != '0) ? ST_PS_RD : ST_OFF_EMIT;
              end
              KIND_TICK:  state_q <= ST_DIV_WAIT;
              KIND_FLUSH: begin
                rst_kind_q <= 1'b0;
                state_q    <= ST_FL_RD;
              end
              KIND_SET:   tick_q <= in_tick;
              KIND_RESET: begin
                tick_q     <= '0;
                rst_kind_q <= 1'b1;
                state_q    <= ST_FL_RD;
              end
              default: ;
            endcase
          end
        end
        ST_PS_RD: begin
          if (px_q == '0) begin
            state_q <= ST_ON_EMIT;
          end else begin
            px_q    <= px_q - ONE;
            state_q <= ST_PS_CMP;
          end
        end
        ST_PS_CMP: begin
          if (!pmatch) begin
            state_q <= ST_PS_RD;
          end else if (out_free) begin
            ax_q    <= a_used_q;
            sx_q    <= px_q;
            a_ret_q <= ST_PH_RD;
            p_ret_q <= ST_ON_EMIT;
            state_q <= ST_AS_RD;
          end
        end
        ST_ON_EMIT: begin
          if (out_free) begin
            if (a_used_q < FULL) begin
              a_used_q <= a_used_q + ONE;
            end
            state_q <= ((dur_q != '0) && !drop) ? ST_SCHED : ST_FINISH;
          end
        end
        ST_SCHED: begin
          p_used_q <= p_used_q + ONE;
          state_q  <= ST_FINISH;
        end
        ST_OFF_EMIT: begin
          if (out_free) begin
            ax_q    <= a_used_q;
            a_ret_q <= ST_FINISH;
            state_q <= ST_AS_RD;
          end
        end
        ST_DIV_WAIT: begin
          if (!div_busy && out_free) begin
            px_q    <= p_used_q;
            state_q <= ST_TK_RD;
          end
        end
        ST_TK_RD: begin
          if (px_q == '0) begin
            tick_q  <= tick_q + 32'd1;
            state_q <= ST_FINISH;
          end else begin
            px_q    <= px_q - ONE;
            state_q <= ST_TK_CMP;
          end
        end
        ST_TK_CMP: begin
          if (!due) begin
            state_q <= ST_TK_RD;
          end else if (out_free) begin
            key_q   <= pnd_rd.key;
            ax_q    <= a_used_q;
            sx_q    <= px_q;
            a_ret_q <= ST_PH_RD;
            p_ret_q <= ST_TK_RD;
            state_q <= ST_AS_RD;
          end
        end
        ST_AS_RD: begin
          if (ax_q == '0) begin
            state_q <= a_ret_q;
          end else begin
            ax_q    <= ax_q - ONE;
            state_q <= ST_AS_CMP;
          end
        end
        ST_AS_CMP: begin
          state_q <= amatch ? ST_AH_RD : ST_AS_RD;
        end
        ST_AH_RD: begin
          if ((ax_q + ONE) < a_used_q) begin
            state_q <= ST_AH_WR;
          end else begin
            a_used_q <= a_used_q - ONE;
            state_q  <= a_ret_q;
          end
        end
        ST_AH_WR: begin
          ax_q    <= ax_q + ONE;
          state_q <= ST_AH_RD;
        end
        ST_PH_RD: begin
          if ((sx_q + ONE) < p_used_q) begin
            state_q <= ST_PH_WR;
          end else begin
            p_used_q <= p_used_q - ONE;
            state_q  <= p_ret_q;
          end
        end
        ST_PH_WR: begin
          sx_q    <= sx_q + ONE;
          state_q <= ST_PH_RD;
        end
        ST_FL_RD: begin
          if (a_used_q != '0) begin
            a_used_q <= a_used_q - ONE;
            state_q  <= ST_FL_EM;
          end else begin
            p_used_q <= '0;
            state_q  <= rst_kind_q ? ST_MARK : ST_FINISH;
          end
        end
        ST_FL_EM: begin
          if (out_free) begin
            state_q <= ST_FL_RD;
          end
        end
        ST_MARK: begin
          if (out_free) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!hold_v_q || out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.off_dropped, out_q.tick_value, out_q.channel,
                          out_q.velocity, out_q.pitch};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_used_q <= FULL) else $error("pending count above capacity");
  a_act_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_used_q <= FULL) else $error("active count above capacity");
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !hold_v_q) else $error("ready with a held result");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> state_q == ST_IDLE) else $error("final result without return to idle");
`endif

endmodule
`default_nettype wire

// File: tb/tb_note_off_scheduler.sv
`timescale 1ns / 1ps

module tb_note_off_scheduler;
  import nos_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned ITEMS_PER_PHASE = 88;

  class note_scoreboard;
    typedef struct {
      bit [31:0] target;
      bit [6:0]  pitch;
      bit [4:0]  chan;
    } pend_entry_t;

    typedef struct {
      bit [6:0] pitch;
      bit [4:0] chan;
    } act_entry_t;

    typedef struct {
      bit [1:0]  kind;
      bit [6:0]  pitch;
      bit [6:0]  velocity;
      bit [4:0]  chan;
      bit [23:0] tick_value;
      bit        dropped;
      bit        last;
    } msg_t;

    bit [15:0]   ticks_per_beat;
    bit [23:0]   tick_wrap;
    bit [31:0]   tick_count;
    pend_entry_t pending[$];
    act_entry_t  sounding[$];
    msg_t        expected_msgs[$];
    int          errors;
    int          results;
    int          items;
    int          drops;
    int          max_burst;

    function new();
      ticks_per_beat = TPB_RESET;
      tick_wrap      = WRAP_RESET;
      tick_count     = '0;
      errors         = 0;
      results        = 0;
      items          = 0;
      drops          = 0;
      max_burst      = 0;
    endfunction

    function void write_reg(logic idx, bit [23:0] value);
      if (idx == CFG_TPB) begin
        ticks_per_beat = value[15:0];
      end else begin
        tick_wrap = value;
      end
    endfunction

    function void push_msg(bit [1:0] kind, bit [6:0] p, bit [6:0] v, bit [4:0] c,
                           bit [23:0] tv, bit drop);
      msg_t m;
      m.kind       = kind;
      m.pitch      = p;
      m.velocity   = v;
      m.chan       = c;
      m.tick_value = tv;
      m.dropped    = drop;
      m.last       = 1'b0;
      expected_msgs.push_back(m);
    endfunction

    function void sound(bit [6:0] p, bit [6:0] v, bit [4:0] c, bit drop);
      act_entry_t a;
      if (v != 0) begin
        if (sounding.size() < DEPTH) begin
          a.pitch = p;
          a.chan  = c;
          sounding.push_back(a);
        end
      end else begin
        for (int i = sounding.size() - 1; i >= 0; i--) begin
          if (sounding[i].pitch == p && sounding[i].chan == c) begin
            sounding.delete(i);
            break;
          end
        end
      end
      push_msg(OUT_NOTE, p, v, c, '0, drop);
    endfunction

    function void silence_all();
      act_entry_t a;
      while (sounding.size() > 0) begin
        a = sounding.pop_back();
        push_msg(OUT_NOTE, a.pitch, '0, a.chan, '0, 1'b0);
      end
      pending.delete();
    endfunction

    function void note_input(bit [2:0] kind, bit [6:0] p, bit [6:0] v, bit [4:0] c,
                             bit [15:0] dur, bit [31:0] nt);
      int          before_cnt;
      bit          drop;
      bit          sched;
      bit [63:0]   t;
      pend_entry_t e;
      before_cnt = expected_msgs.size();
      items++;
      drop  = 1'b0;
      sched = 1'b0;
      case (kind)
        KIND_NOTE: begin
          if (v != 0) begin
            for (int i = pending.size() - 1; i >= 0; i--) begin
              if (pending[i].pitch == p && pending[i].chan == c) begin
                sound(p, '0, c, 1'b0);
                pending.delete(i);
                break;
              end
            end
            if (dur != 0) begin
              if (pending.size() >= DEPTH) drop = 1'b1;
              else sched = 1'b1;
            end
          end
          if (drop) drops++;
          sound(p, v, c, drop);
          if (sched) begin
            t = 64'(tick_count) + ((64'(dur) * 64'(ticks_per_beat)) >> 8);
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            e.target = t[31:0];
            e.pitch  = p;
            e.chan   = c;
            pending.push_back(e);
          end
        end
        KIND_TICK: begin
          push_msg(OUT_TICK, '0, '0, '0,
                   (tick_wrap != 0) ? 24'(tick_count % tick_wrap) : tick_count[23:0], 1'b0);
          for (int i = pending.size() - 1; i >= 0; i--) begin
            if (tick_count >= pending[i].target) begin
              sound(pending[i].pitch, '0, pending[i].chan, 1'b0);
              pending.delete(i);
            end
          end
          tick_count = tick_count + 1;
        end
        KIND_FLUSH: silence_all();
        KIND_SET: tick_count = nt;
        KIND_RESET: begin
          tick_count = '0;
          silence_all();
          push_msg(OUT_MARKER, '0, '0, '0, '0, 1'b0);
        end
        default: ;
      endcase
      if (expected_msgs.size() > before_cnt) begin
        expected_msgs[$].last = 1'b1;
        if (expected_msgs.size() - before_cnt > max_burst)
          max_burst = expected_msgs.size() - before_cnt;
      end
    endfunction

    function void report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endfunction

    function void check_result(bit [1:0] kind, bit [47:0] data, bit last);
      msg_t m;
      results++;
      if (expected_msgs.size() == 0) begin
        report($sformatf("unexpected result kind %0d data %h last %0d", kind, data, last));
        return;
      end
      m = expected_msgs.pop_front();
      if (kind != m.kind || data[6:0] != m.pitch || data[13:7] != m.velocity ||
          data[18:14] != m.chan || data[42:19] != m.tick_value ||
          data[43] != m.dropped || last != m.last) begin
        report($sformatf({"got kind %0d p %0d v %0d c %0d tv %0d drop %0d last %0d, ",
                          "want kind %0d p %0d v %0d c %0d tv %0d drop %0d last %0d"},
                         kind, data[6:0], data[13:7], data[18:14], data[42:19],
                         data[43], last, m.kind, m.pitch, m.velocity, m.chan,
                         m.tick_value, m.dropped, m.last));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [23:0] cfg_data_i;

  note_scoreboard sb;
  bit             src_quiet;
  bit             sink_quiet;
  bit             long_hold_req;
  bit             long_hold_done;

  note_off_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_event(bit [2:0] kind, bit [6:0] p, bit [6:0] v, bit [4:0] c,
                            bit [15:0] dur, bit [31:0] nt);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, nt, dur, c, v, p};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, p, v, c, dur, nt);
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_msgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, bit [23:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_random_event(int tick_pct);
    int        r;
    bit [2:0]  kind;
    bit [6:0]  p;
    bit [6:0]  v;
    bit [4:0]  c;
    bit [15:0] dur;
    bit [31:0] nt;
    r   = $urandom_range(0, 99);
    p   = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 15)) : 7'($urandom);
    c   = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 4)) : 5'($urandom);
    v   = ($urandom_range(0, 9) < 3) ? 7'd0 : 7'($urandom_range(1, 127));
    dur = 16'($urandom);
    nt  = $urandom;
    if (r < 60) begin
      kind = KIND_NOTE;
      r = $urandom_range(0, 9);
      if (r < 2) dur = '0;
      else if (r < 8) dur = 16'($urandom_range(1, 16'h0300));
    end else if (r < 60 + tick_pct) begin
      kind = KIND_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) kind = KIND_FLUSH;
      else if (r < 65) begin
        kind = KIND_SET;
        if ($urandom_range(0, 2) == 0) nt = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else if ($urandom_range(0, 1) == 0) nt = $urandom_range(0, 2000);
      end
      else if (r < 80) kind = KIND_RESET;
      else kind = 3'($urandom_range(5, 7));
    end
    send_event(kind, p, v, c, dur, nt);
  endtask

  initial begin
    bit [15:0] tpb_set[5]  = '{16'd180, 16'd1, 16'd65535, 16'd0, 16'd7};
    bit [23:0] wrap_set[5] = '{24'd15999840, 24'd1, 24'd16000000, 24'd0, 24'd13};
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_TPB;
    cfg_data_i    = '0;
    src_quiet     = 1'b0;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_event(KIND_NOTE, 7'd0, 7'd1, 5'd1, 16'h0100, 32'h0);
    send_event(KIND_NOTE, 7'd127, 7'd127, 5'd16, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(KIND_NOTE, 7'd0, 7'd1, 5'd1, 16'h0000, 32'h0);
    send_event(KIND_NOTE, 7'd127, 7'd0, 5'd16, 16'h0000, 32'h0);
    send_event(KIND_NOTE, 7'd5, 7'd0, 5'd3, 16'h0000, 32'h0);
    send_event(KIND_NOTE, 7'd9, 7'd64, 5'd31, 16'h0001, 32'h0);
    send_event(KIND_TICK, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_TICK, 7'd127, 7'd127, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(KIND_TICK, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_SET, 7'd0, 7'd0, 5'd0, 16'h0, 32'hFFFF_FFFE);
    send_event(KIND_NOTE, 7'd20, 7'd100, 5'd0, 16'hFFFF, 32'h0);
    send_event(KIND_NOTE, 7'd21, 7'd100, 5'd2, 16'h0080, 32'h0);
    send_event(KIND_TICK, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_TICK, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_TICK, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_FLUSH, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_FLUSH, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(3'd5, 7'd1, 7'd1, 5'd1, 16'h1, 32'h1);
    send_event(3'd6, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(3'd7, 7'd127, 7'd127, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(KIND_NOTE, 7'd3, 7'd1, 5'd4, 16'h0200, 32'h0);
    send_event(KIND_RESET, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);
    send_event(KIND_SET, 7'd0, 7'd0, 5'd0, 16'h0, 32'h0);

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_settle();
      write_cfg(CFG_TPB, 24'(tpb_set[ph]));
      write_cfg(CFG_WRAP, wrap_set[ph]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 30 == 0) src_quiet = ($urandom_range(0, 3) == 0);
        if (ph == 0 && k == 40) long_hold_req = 1'b1;
        send_random_event((ph == 2) ? 6 : 20);
      end
    end

    drain_and_settle();
    $display("Sent %0d events and checked %0d results; %0d note-offs dropped on a full store.",
             sb.items, sb.results, sb.drops);
    $display("Largest burst from one event was %0d results; %0d mismatches.",
             sb.max_burst, sb.errors);
    if (sb.errors == 0 && long_hold_done) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int stall;
    m_axis_tready  = 1'b0;
    sink_quiet     = 1'b0;
    long_hold_done = 1'b0;
    stall          = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if ($urandom_range(0, 199) == 0) sink_quiet = ~sink_quiet;
      if (long_hold_req && !long_hold_done) begin
        m_axis_tready  <= 1'b0;
        long_hold_done = 1'b1;
        stall          = 600;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= (stall == 0);
      end else begin
        stall = pick_gap(sink_quiet);
        m_axis_tready <= (stall == 0);
      end
    end
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule
